@@ rtl/htfd_pkg.sv @@
// Shared types, constants and the CRC-8 byte step of the frame decoder.
package htfd_pkg;

    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'h31;
    localparam logic [7:0] INIT_MASK = 8'h18;
    localparam logic [7:0] BUSY_MASK = 8'h80;

    localparam int HUM_W   = 10;
    localparam int TEMP_W  = 12;
    localparam int RAW_W   = 20;
    localparam int FRAC_W  = 20;
    localparam logic [9:0]  HUM_SCALE   = 10'd1000;
    localparam logic [10:0] TEMP_SCALE  = 11'd2000;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 12'd500;

    typedef logic [2:0] pos_t;
    localparam pos_t POS_STATUS = 3'd0;
    localparam pos_t POS_HUM_HI = 3'd1;
    localparam pos_t POS_HUM_MID = 3'd2;
    localparam pos_t POS_SPLIT  = 3'd3;
    localparam pos_t POS_TEMP_MID = 3'd4;
    localparam pos_t POS_TEMP_LO = 3'd5;
    localparam pos_t POS_CHECK  = 3'd6;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BUSY    = 2'd1,
        STATUS_CRC_ERR = 2'd2
    } status_t;

    typedef struct packed {
        logic [HUM_W-1:0]         humidity_tenths;
        logic signed [TEMP_W-1:0] temperature_tenths;
        status_t                  status_code;
        logic                     needs_init;
    } result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/htfd_frame.sv @@
// Frame tracker: byte position, running CRC, raw field assembly and result formation.
module htfd_frame
    import htfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic [7:0]  rx_byte,
    input  logic        frame_first,
    output logic        is_last,
    output result_t     result
);

    pos_t              pos_reg, pos_next, pos_eff;
    logic [7:0]        crc_reg, crc_next, crc_step;
    logic [7:0]        status_reg, status_next;
    logic [RAW_W-1:0]  hum_raw_reg, hum_raw_next;
    logic [RAW_W-1:0]  tem_raw_reg, tem_raw_next;
    logic [RAW_W+HUM_W-1:0]  hum_prod;
    logic [RAW_W+10:0]       tem_prod;
    logic [TEMP_W-1:0]       tem_scaled;
    status_t           code;

    always_comb begin
        pos_eff = (frame_first || pos_reg > POS_CHECK) ? POS_STATUS : pos_reg;
        is_last = (pos_eff == POS_CHECK);
        crc_step = crc8_byte((pos_eff == POS_STATUS) ? CRC_INIT : crc_reg, rx_byte);

        pos_next     = pos_reg;
        crc_next     = crc_reg;
        status_next  = status_reg;
        hum_raw_next = hum_raw_reg;
        tem_raw_next = tem_raw_reg;
        if (advance) begin
            pos_next = pos_eff + 3'd1;
            crc_next = crc_step;
            case (pos_eff)
                POS_STATUS: begin
                    status_next  = rx_byte;
                    hum_raw_next = '0;
                    tem_raw_next = '0;
                end
                POS_HUM_HI:   hum_raw_next[19:12] = rx_byte;
                POS_HUM_MID:  hum_raw_next[11:4]  = rx_byte;
                POS_SPLIT: begin
                    hum_raw_next[3:0]   = rx_byte[7:4];
                    tem_raw_next[19:16] = rx_byte[3:0];
                end
                POS_TEMP_MID: tem_raw_next[15:8] = rx_byte;
                POS_TEMP_LO:  tem_raw_next[7:0]  = rx_byte;
                default: begin
                    pos_next = POS_STATUS;
                    crc_next = CRC_INIT;
                end
            endcase
        end

        if ((status_reg & BUSY_MASK) != 8'h00) begin
            code = STATUS_BUSY;
        end else if (crc_reg != rx_byte) begin
            code = STATUS_CRC_ERR;
        end else begin
            code = STATUS_OK;
        end

        hum_prod   = hum_raw_reg * HUM_SCALE;
        tem_prod   = tem_raw_reg * TEMP_SCALE;
        tem_scaled = {1'b0, tem_prod[RAW_W+10:FRAC_W]} - TEMP_OFFSET;

        result.status_code = code;
        result.needs_init  = ((status_reg & INIT_MASK) != INIT_MASK);
        if (code == STATUS_OK) begin
            result.humidity_tenths    = hum_prod[RAW_W+HUM_W-1:FRAC_W];
            result.temperature_tenths = signed'(tem_scaled);
        end else begin
            result.humidity_tenths    = '0;
            result.temperature_tenths = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_STATUS;
            crc_reg <= CRC_INIT;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
        status_reg  <= status_next;
        hum_raw_reg <= hum_raw_next;
        tem_raw_reg <= tem_raw_next;
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_CHECK)
        else $error("frame position out of range");

    a_last_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_last |=> pos_reg == POS_STATUS && crc_reg == CRC_INIT)
        else $error("frame did not restart after check byte");

    a_first_resync: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && frame_first |=> pos_reg == POS_HUM_HI)
        else $error("frame start did not resynchronize position");

endmodule

@@ rtl/humidity_temperature_frame_decoder.sv @@
// Top level of the humidity/temperature reading-frame decoder.
// Takes one frame byte per request on the s_ channel and emits one result per
// seven-byte frame on the m_ channel after the check byte. One byte is taken
// every cycle unless stalled; a byte passes an input register, a single pass of
// CRC, field assembly and scaling logic, and the result register, so a result
// is offered once its check byte has passed both. Bytes that produce no result keep
// flowing while a result waits on the output; the input stalls only when the
// next check byte reaches the input register while the previous result waits.
module humidity_temperature_frame_decoder
    import htfd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,
    input  logic                     s_frame_first,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [HUM_W-1:0]         m_humidity_tenths,
    output logic signed [TEMP_W-1:0] m_temperature_tenths,
    output logic [1:0]               m_status_code,
    output logic                     m_needs_init
);

    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       first_reg;
    logic       m_valid_reg, m_valid_next;
    result_t    res_reg;
    result_t    res_comb;
    logic       is_last;
    logic       advance;

    htfd_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .rx_byte     (byte_reg),
        .frame_first (first_reg),
        .is_last     (is_last),
        .result      (res_comb)
    );

    assign advance = in_vld_reg && (!is_last || !m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance && is_last) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            m_valid_reg <= m_valid_next;
        end
        if (s_valid && s_ready) begin
            byte_reg  <= s_rx_byte;
            first_reg <= s_frame_first;
        end
        if (advance && is_last) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_humidity_tenths    = res_reg.humidity_tenths;
    assign m_temperature_tenths = res_reg.temperature_tenths;
    assign m_status_code        = res_reg.status_code;
    assign m_needs_init         = res_reg.needs_init;

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld_reg && is_last && m_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_last |-> !m_valid_reg || m_ready)
        else $error("result register overwritten before it was taken");

    a_not_ok_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status_code != STATUS_OK |->
            m_humidity_tenths == '0 && m_temperature_tenths == '0)
        else $error("nonzero readings on a failed frame");

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(advance && is_last))
        else $error("result raised without a check byte");

endmodule

@@ tb/humidity_temperature_frame_decoder_tb.sv @@
// Self-checking testbench for the humidity/temperature reading-frame decoder.
module humidity_temperature_frame_decoder_tb
    import htfd_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SINK_HOLD_CYCLES = 200;

    typedef struct {
        logic [HUM_W-1:0]         hum;
        logic signed [TEMP_W-1:0] temp;
        status_t                  code;
        logic                     init;
    } reading_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [7:0]               s_rx_byte;
    logic                     s_frame_first;
    logic                     m_valid;
    logic                     m_ready;
    logic [HUM_W-1:0]         m_humidity_tenths;
    logic signed [TEMP_W-1:0] m_temperature_tenths;
    logic [1:0]               m_status_code;
    logic                     m_needs_init;

    pos_t         frame_pos;
    logic [7:0]   frame_crc;
    logic [7:0]   frame_status;
    logic [RAW_W-1:0] hum_raw;
    logic [RAW_W-1:0] temp_raw;
    reading_t     pending_readings[$];
    reading_t     head_reading;

    bit sender_gaps;
    bit sink_stalls;
    int sink_hold_left;
    int sink_stall_left;
    int idle_cycles;
    int error_count;
    int bytes_sent;
    int frames_sent;
    int readings_seen;
    int ok_seen;
    int busy_seen;
    int crc_err_seen;
    int input_stall_cycles;

    humidity_temperature_frame_decoder i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rx_byte            (s_rx_byte),
        .s_frame_first        (s_frame_first),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_humidity_tenths    (m_humidity_tenths),
        .m_temperature_tenths (m_temperature_tenths),
        .m_status_code        (m_status_code),
        .m_needs_init         (m_needs_init)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void decode_frame_byte(input logic [7:0] b, input logic first);
        pos_t        pos;
        reading_t    r;
        logic [39:0] scaled;
        pos = (first || frame_pos > POS_CHECK) ? POS_STATUS : frame_pos;
        case (pos)
            POS_STATUS: begin
                frame_status = b;
                frame_crc = crc_step(CRC_INIT, b);
                hum_raw = '0;
                temp_raw = '0;
            end
            POS_HUM_HI: begin
                frame_crc = crc_step(frame_crc, b);
                hum_raw[19:12] = b;
            end
            POS_HUM_MID: begin
                frame_crc = crc_step(frame_crc, b);
                hum_raw[11:4] = b;
            end
            POS_SPLIT: begin
                frame_crc = crc_step(frame_crc, b);
                hum_raw[3:0] = b[7:4];
                temp_raw[19:16] = b[3:0];
            end
            POS_TEMP_MID: begin
                frame_crc = crc_step(frame_crc, b);
                temp_raw[15:8] = b;
            end
            POS_TEMP_LO: begin
                frame_crc = crc_step(frame_crc, b);
                temp_raw[7:0] = b;
            end
            default: begin
                r.hum = '0;
                r.temp = '0;
                r.init = ((frame_status & INIT_MASK) != INIT_MASK);
                if ((frame_status & BUSY_MASK) != 0) begin
                    r.code = STATUS_BUSY;
                end else if (frame_crc != b) begin
                    r.code = STATUS_CRC_ERR;
                end else begin
                    r.code = STATUS_OK;
                    scaled = (40'(hum_raw) * 40'(HUM_SCALE)) >> FRAC_W;
                    r.hum = scaled[HUM_W-1:0];
                    scaled = (40'(temp_raw) * 40'(TEMP_SCALE)) >> FRAC_W;
                    r.temp = scaled[TEMP_W-1:0] - TEMP_OFFSET;
                end
                pending_readings.push_back(r);
                frame_pos = POS_STATUS;
                frame_crc = CRC_INIT;
                return;
            end
        endcase
        frame_pos = pos + 3'd1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        error_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_rx_byte = b;
        s_frame_first = first;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        decode_frame_byte(b, first);
        bytes_sent++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] status, input logic [39:0] payload,
                              input logic bad_crc, input logic first);
        logic [7:0] crc;
        logic [7:0] check;
        crc = crc_step(CRC_INIT, status);
        for (int i = 4; i >= 0; i--) crc = crc_step(crc, payload[i*8 +: 8]);
        check = bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc;
        send_byte(status, first);
        for (int i = 4; i >= 0; i--) send_byte(payload[i*8 +: 8], 1'b0);
        send_byte(check, 1'b0);
        frames_sent++;
    endtask

    task automatic test_directed();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        // drop a partial frame by restarting mid-frame
        send_byte(8'h00, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_frame(8'h18, 40'h00_00_00_00_00, 1'b0, 1'b1);
        // status byte taken at position zero without a frame start flag
        send_frame(8'h1C, 40'hFF_FF_FF_FF_FF, 1'b0, 1'b0);
        // busy with a bad check byte, needs init
        send_frame(8'h88, 40'h12_34_56_78_9A, 1'b1, 1'b1);
        release_input();
    endtask

    task automatic test_random_frames(input int byte_target);
        int          r;
        int          cut;
        logic [7:0]  status;
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        while (bytes_sent < byte_target) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                status = 8'($urandom);
                if ($urandom_range(0, 9) < 7) status[7] = 1'b0;
                if ($urandom_range(0, 9) < 6) status[4:3] = 2'b11;
                send_frame(status, {$urandom, 8'($urandom)},
                           $urandom_range(0, 99) < 15, $urandom_range(0, 9) != 0);
            end else if (r < 93) begin
                cut = $urandom_range(1, 6);
                send_byte(8'($urandom), 1'b1);
                repeat (cut - 1) send_byte(8'($urandom), 1'b0);
            end else begin
                send_byte(8'($urandom), 1'($urandom));
            end
        end
        release_input();
    endtask

    task automatic test_output_hold_off(input int frames);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        sink_hold_left = SINK_HOLD_CYCLES;
        repeat (frames) begin
            send_frame({$urandom_range(0, 1) ? 8'h18 : 8'h1C},
                       {$urandom, 8'($urandom)}, 1'b0, 1'b1);
        end
        release_input();
    endtask

    task automatic test_streaming(input int frames);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        repeat (frames) begin
            send_frame({1'b0, 7'($urandom)}, {$urandom, 8'($urandom)},
                       $urandom_range(0, 9) == 0, 1'b1);
        end
        release_input();
    endtask

    // receiver: hold off on request, otherwise stall at random when stalls are enabled
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_left > 0) begin
                m_ready = 1'b0;
                sink_hold_left--;
            end else if (sink_stall_left > 0) begin
                m_ready = 1'b0;
                sink_stall_left--;
            end else begin
                m_ready = 1'b1;
                if (sink_stalls) sink_stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            readings_seen++;
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected reading", readings_seen, 0);
            end else begin
                head_reading = pending_readings.pop_front();
                case (head_reading.code)
                    STATUS_OK:   ok_seen++;
                    STATUS_BUSY: busy_seen++;
                    default:     crc_err_seen++;
                endcase
                if (m_humidity_tenths !== head_reading.hum)
                    report_mismatch("humidity_tenths", m_humidity_tenths, head_reading.hum);
                if (m_temperature_tenths !== head_reading.temp)
                    report_mismatch("temperature_tenths", int'(m_temperature_tenths),
                                    int'(head_reading.temp));
                if (m_status_code !== head_reading.code)
                    report_mismatch("status_code", m_status_code, head_reading.code);
                if (m_needs_init !== head_reading.init)
                    report_mismatch("needs_init", m_needs_init, head_reading.init);
            end
        end
    end

    always @(posedge aclk) begin
        if (s_valid && !s_ready) input_stall_cycles++;
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'h00;
        s_frame_first = 1'b0;
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        sink_hold_left = 0;
        sink_stall_left = 0;
        idle_cycles = 0;
        error_count = 0;
        bytes_sent = 0;
        frames_sent = 0;
        readings_seen = 0;
        ok_seen = 0;
        busy_seen = 0;
        crc_err_seen = 0;
        input_stall_cycles = 0;
        frame_pos = POS_STATUS;
        frame_crc = CRC_INIT;
        frame_status = 8'h00;
        hum_raw = '0;
        temp_raw = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_frames(1000);
        test_output_hold_off(6);
        test_streaming(12);

        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d bytes in %0d whole frames plus broken and stray bytes",
                 bytes_sent, frames_sent);
        $display("Checked %0d readings: %0d ok, %0d busy, %0d crc error; input stalled %0d cycles",
                 readings_seen, ok_seen, busy_seen, crc_err_seen, input_stall_cycles);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
